// File: hw/rtl/ssd_pkg.sv
// Shared types and constants for the dielectric specular sampler.
// No dependencies; imported by every module of the block.
`default_nettype none

package ssd_pkg;

    localparam logic [15:0] ONE_Q15    = 16'd32768;
    localparam logic [23:0] WEIGHT_MAX = 24'hFF_FFFF;
    localparam logic [62:0] COS2_ONE   = 63'd1 << 56;
    localparam logic [30:0] SIN2_ONE   = 31'd1 << 30;

    // Pipelined square root: one result bit per stage
    localparam int SQRT_STAGES = 16;

    // Pipelined restoring divider: one quotient bit per stage
    localparam int DIV_N_W = 48;
    localparam int DIV_D_W = 33;
    localparam int DIV_Q_W = 25;

    // Configuration register indexes
    localparam logic [1:0] CFG_RATIO_ENTERING = 2'd0;
    localparam logic [1:0] CFG_RATIO_LEAVING  = 2'd1;
    localparam logic [1:0] CFG_INDEX_OUTSIDE  = 2'd2;
    localparam logic [1:0] CFG_INDEX_INSIDE   = 2'd3;

    typedef enum logic [1:0] {
        LOBE_NONE  = 2'd0,
        LOBE_REFL  = 2'd1,
        LOBE_TRANS = 2'd2
    } lobe_t;

    // Ray state carried through the front end and the square root
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic        entering;
        logic [15:0] abs_z;
        logic [15:0] e;
        logic [15:0] smp;
        logic        refl_ok;
        logic        trans_ok;
    } ray_t;

    // Ray state carried through the Fresnel divisions
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [17:0] mx;
        logic [17:0] my;
        logic        entering;
        logic [15:0] abs_z;
        logic [15:0] cost;
        logic [15:0] smp;
        logic        refl_ok;
        logic        trans_ok;
    } fres_t;

    // Chosen result carried through the weight division
    typedef struct packed {
        logic [16:0] dx;
        logic [16:0] dy;
        logic [16:0] dz;
        logic [15:0] prob;
        logic        lum;
        lobe_t       lobe;
    } sel_t;

    localparam int RAY_W  = $bits(ray_t);
    localparam int FRES_W = $bits(fres_t);
    localparam int SEL_W  = $bits(sel_t);
    localparam int SIDE_W = (FRES_W > RAY_W) ? ((FRES_W > SEL_W) ? FRES_W : SEL_W)
                                             : ((RAY_W > SEL_W) ? RAY_W : SEL_W);

endpackage

`default_nettype wire

// File: hw/rtl/ssd_front.sv
// Front end: ratio select, squares and the refracted cos^2 argument.
// Depends on ssd_pkg.
`default_nettype none

module ssd_front
    import ssd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        adv,
    input  wire logic        in_valid,
    input  wire logic [15:0] in_x,
    input  wire logic [15:0] in_y,
    input  wire logic [15:0] in_z,
    input  wire logic [15:0] in_smp,
    input  wire logic        in_refl_ok,
    input  wire logic        in_trans_ok,
    input  wire logic [15:0] ratio_ent,
    input  wire logic [15:0] ratio_lvg,
    output logic             out_valid,
    output logic [30:0]      out_arg,
    output ray_t             out_ray
);

    logic        s1_vld_reg, s2_vld_reg, s3_vld_reg;
    ray_t        s1_ray_reg, s2_ray_reg, s3_ray_reg;
    logic [31:0] s1_e2_reg;
    logic [30:0] s1_az2_reg;
    logic [62:0] s2_term_reg;
    logic [30:0] s3_arg_reg;

    ray_t        ray_next;
    logic [31:0] e2_next;
    logic [30:0] az2_next;
    logic [30:0] sin2;
    logic [62:0] term_next;
    logic [62:0] cos2_diff;
    logic [30:0] arg_next;

    // stage 1: side, |z|, e^2 and z^2
    always_comb
    begin
        ray_next.x        = in_x;
        ray_next.y        = in_y;
        ray_next.entering = !in_z[15] && (in_z != 16'd0);
        ray_next.abs_z    = in_z[15] ? 16'(16'd0 - in_z) : in_z;
        ray_next.e        = ray_next.entering ? ratio_ent : ratio_lvg;
        ray_next.smp      = in_smp;
        ray_next.refl_ok  = in_refl_ok;
        ray_next.trans_ok = in_trans_ok;
        e2_next           = 32'(ray_next.e) * 32'(ray_next.e);
        az2_next          = 31'(32'(ray_next.abs_z) * 32'(ray_next.abs_z));
    end

    // stage 2: e^2 * sin^2
    assign sin2      = SIN2_ONE - s1_az2_reg;
    assign term_next = 63'(s1_e2_reg) * 63'(sin2);

    // stage 3: clamp and rescale to Q.30
    assign cos2_diff = COS2_ONE - s2_term_reg;
    assign arg_next  = (s2_term_reg >= COS2_ONE) ? 31'd0 : 31'(cos2_diff >> 26);

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ray_reg  <= ray_next;
            s1_e2_reg   <= e2_next;
            s1_az2_reg  <= az2_next;
            s2_ray_reg  <= s1_ray_reg;
            s2_term_reg <= term_next;
            s3_ray_reg  <= s2_ray_reg;
            s3_arg_reg  <= arg_next;
        end
    end

    assign out_valid = s3_vld_reg;
    assign out_arg   = s3_arg_reg;
    assign out_ray   = s3_ray_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ssd_sqrt.sv
// Pipelined integer square root, one result bit per stage, with side data.
// Depends on ssd_pkg.
`default_nettype none

module ssd_sqrt
    import ssd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire logic [30:0]       in_arg,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [15:0]            out_root,
    output logic [SIDE_W-1:0]      out_side
);

    logic              vld_reg  [SQRT_STAGES];
    logic [30:0]       v_reg    [SQRT_STAGES];
    logic [31:0]       r_reg    [SQRT_STAGES];
    logic [SIDE_W-1:0] side_reg [SQRT_STAGES];

    for (genvar i = 0; i < SQRT_STAGES; i++)
    begin : g_st
        localparam logic [31:0] BIT = 32'd1 << (2 * (SQRT_STAGES - 1 - i));
        logic              vld_in;
        logic [30:0]       v_in;
        logic [31:0]       r_in;
        logic [SIDE_W-1:0] side_in;
        logic [31:0]       cand;
        logic [30:0]       v_next;
        logic [31:0]       r_next;

        if (i == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign v_in    = in_arg;
            assign r_in    = 32'd0;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[i-1];
            assign v_in    = v_reg[i-1];
            assign r_in    = r_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        // one digit of the root
        always_comb
        begin
            cand = r_in + BIT;
            if (32'(v_in) >= cand)
            begin
                v_next = 31'(32'(v_in) - cand);
                r_next = (r_in >> 1) + BIT;
            end
            else
            begin
                v_next = v_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (adv)
                vld_reg[i] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                v_reg[i]    <= v_next;
                r_reg[i]    <= r_next;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[SQRT_STAGES-1];
    assign out_root  = r_reg[SQRT_STAGES-1][15:0];
    assign out_side  = side_reg[SQRT_STAGES-1];

endmodule

`default_nettype wire

// File: hw/rtl/ssd_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side data.
// Flags overflow when the quotient does not fit (including a zero divisor).
// Depends on ssd_pkg.
`default_nettype none

module ssd_div
    import ssd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire logic               in_valid,
    input  wire logic [DIV_N_W-1:0] in_num,
    input  wire logic [DIV_D_W-1:0] in_den,
    input  wire logic [SIDE_W-1:0]  in_side,
    output logic                    out_valid,
    output logic [DIV_Q_W-1:0]      out_quo,
    output logic                    out_ovf,
    output logic [SIDE_W-1:0]       out_side
);

    logic               vld_reg  [DIV_Q_W];
    logic [DIV_D_W-1:0] rem_reg  [DIV_Q_W];
    logic [DIV_Q_W-1:0] low_reg  [DIV_Q_W];
    logic [DIV_Q_W-1:0] q_reg    [DIV_Q_W];
    logic [DIV_D_W-1:0] den_reg  [DIV_Q_W];
    logic               ovf_reg  [DIV_Q_W];
    logic [SIDE_W-1:0]  side_reg [DIV_Q_W];

    for (genvar i = 0; i < DIV_Q_W; i++)
    begin : g_st
        logic               vld_in;
        logic [DIV_D_W-1:0] rem_in;
        logic [DIV_Q_W-1:0] low_in;
        logic [DIV_Q_W-1:0] q_in;
        logic [DIV_D_W-1:0] den_in;
        logic               ovf_in;
        logic [SIDE_W-1:0]  side_in;
        logic [DIV_D_W:0]   trial;
        logic               ge;
        logic [DIV_D_W-1:0] rem_next;

        if (i == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = DIV_D_W'(in_num[DIV_N_W-1:DIV_Q_W]);
            assign low_in  = in_num[DIV_Q_W-1:0];
            assign q_in    = '0;
            assign den_in  = in_den;
            assign ovf_in  = DIV_D_W'(in_num[DIV_N_W-1:DIV_Q_W]) >= in_den;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign low_in  = low_reg[i-1];
            assign q_in    = q_reg[i-1];
            assign den_in  = den_reg[i-1];
            assign ovf_in  = ovf_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        // shift in the next numerator bit and try the subtraction
        always_comb
        begin
            trial    = {rem_in, low_in[DIV_Q_W-1]};
            ge       = trial >= {1'b0, den_in};
            rem_next = ge ? DIV_D_W'(trial - {1'b0, den_in}) : trial[DIV_D_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (adv)
                vld_reg[i] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i]  <= rem_next;
                low_reg[i]  <= {low_in[DIV_Q_W-2:0], 1'b0};
                q_reg[i]    <= {q_in[DIV_Q_W-2:0], ge};
                den_reg[i]  <= den_in;
                ovf_reg[i]  <= ovf_in;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[DIV_Q_W-1];
    assign out_quo   = q_reg[DIV_Q_W-1];
    assign out_ovf   = ovf_reg[DIV_Q_W-1];
    assign out_side  = side_reg[DIV_Q_W-1];

endmodule

`default_nettype wire

// File: hw/rtl/dielectric_specular_sampler.sv
// Throughput: one transaction per cycle; every stage holds while the output
// register is full and not taken, so one result per cycle leaves at most.
// The depth is set by the 16-stage square root and two 25-stage dividers.
// Reset (rst_n low, asynchronous) clears all valid bits and loads the
// default refraction ratios and indexes.
// Depends on ssd_pkg, ssd_front, ssd_sqrt and ssd_div.
`default_nettype none

module dielectric_specular_sampler
    import ssd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration writes
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // out_dir_x, out_dir_y, out_dir_z, sample_value, allow_reflect,
    // allow_transmit, zero pad
    input  wire logic [71:0] s_axis_tdata,
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // in_dir_x, in_dir_y, in_dir_z, prob_density, weight, zero pad
    output logic [95:0]      m_axis_tdata,
    // weight_on_luminance, lobe_chosen
    output logic [2:0]       m_axis_tuser
);

    logic        adv;
    logic [15:0] ratio_ent_reg, ratio_lvg_reg, index_out_reg, index_in_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_ent_reg <= 16'd5461;
            ratio_lvg_reg <= 16'd12288;
            index_out_reg <= 16'd8192;
            index_in_reg  <= 16'd12288;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_RATIO_ENTERING: ratio_ent_reg <= cfg_data;
                CFG_RATIO_LEAVING:  ratio_lvg_reg <= cfg_data;
                CFG_INDEX_OUTSIDE:  index_out_reg <= cfg_data;
                CFG_INDEX_INSIDE:   index_in_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    // whole pipeline moves unless the output register is held
    logic out_vld_reg;
    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // front end
    logic        fr_valid;
    logic [30:0] fr_arg;
    ray_t        fr_ray;

    ssd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (s_axis_tvalid),
        .in_x        (s_axis_tdata[15:0]),
        .in_y        (s_axis_tdata[31:16]),
        .in_z        (s_axis_tdata[47:32]),
        .in_smp      (s_axis_tdata[63:48]),
        .in_refl_ok  (s_axis_tdata[64]),
        .in_trans_ok (s_axis_tdata[65]),
        .ratio_ent   (ratio_ent_reg),
        .ratio_lvg   (ratio_lvg_reg),
        .out_valid   (fr_valid),
        .out_arg     (fr_arg),
        .out_ray     (fr_ray)
    );

    // refracted cosine
    logic              sq_valid;
    logic [15:0]       sq_root;
    logic [SIDE_W-1:0] sq_side;
    ray_t              sq_ray;

    ssd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fr_valid),
        .in_arg    (fr_arg),
        .in_side   (SIDE_W'(fr_ray)),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    assign sq_ray = ray_t'(sq_side[RAY_W-1:0]);

    // products stage: Fresnel terms and scaled x, y
    logic        p_vld_reg;
    logic [31:0] p_a1_reg, p_b1_reg, p_a2_reg, p_b2_reg;
    fres_t       p_side_reg;
    fres_t       p_side_next;
    logic [15:0] abs_x, abs_y;

    always_comb
    begin
        abs_x                = sq_ray.x[15] ? 16'(16'd0 - sq_ray.x) : sq_ray.x;
        abs_y                = sq_ray.y[15] ? 16'(16'd0 - sq_ray.y) : sq_ray.y;
        p_side_next.x        = sq_ray.x;
        p_side_next.y        = sq_ray.y;
        p_side_next.mx       = 18'((32'(abs_x) * 32'(sq_ray.e)) >> 13);
        p_side_next.my       = 18'((32'(abs_y) * 32'(sq_ray.e)) >> 13);
        p_side_next.entering = sq_ray.entering;
        p_side_next.abs_z    = sq_ray.abs_z;
        p_side_next.cost     = sq_root;
        p_side_next.smp      = sq_ray.smp;
        p_side_next.refl_ok  = sq_ray.refl_ok;
        p_side_next.trans_ok = sq_ray.trans_ok;
    end

    // difference stage: magnitudes and sums
    logic               d_vld_reg;
    logic [DIV_N_W-1:0] d_num1_reg, d_num2_reg;
    logic [DIV_D_W-1:0] d_den1_reg, d_den2_reg;
    fres_t              d_side_reg;
    logic [31:0]        mag1, mag2;

    assign mag1 = (p_a1_reg >= p_b1_reg) ? p_a1_reg - p_b1_reg : p_b1_reg - p_a1_reg;
    assign mag2 = (p_a2_reg >= p_b2_reg) ? p_a2_reg - p_b2_reg : p_b2_reg - p_a2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_vld_reg <= sq_valid;
            d_vld_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_a1_reg   <= 32'(index_in_reg) * 32'(sq_ray.abs_z);
            p_b1_reg   <= 32'(index_out_reg) * 32'(sq_root);
            p_a2_reg   <= 32'(index_out_reg) * 32'(sq_ray.abs_z);
            p_b2_reg   <= 32'(index_in_reg) * 32'(sq_root);
            p_side_reg <= p_side_next;
            d_num1_reg <= DIV_N_W'(mag1) << 15;
            d_num2_reg <= DIV_N_W'(mag2) << 15;
            d_den1_reg <= DIV_D_W'(p_a1_reg) + DIV_D_W'(p_b1_reg);
            d_den2_reg <= DIV_D_W'(p_a2_reg) + DIV_D_W'(p_b2_reg);
            d_side_reg <= p_side_reg;
        end
    end

    // Fresnel ratio divisions
    logic               f1_valid, f2_valid, f1_ovf, f2_ovf;
    logic [DIV_Q_W-1:0] f1_quo, f2_quo;
    logic [SIDE_W-1:0]  f1_side;
    fres_t              f_side;

    ssd_div u_div_fres1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (d_vld_reg),
        .in_num    (d_num1_reg),
        .in_den    (d_den1_reg),
        .in_side   (SIDE_W'(d_side_reg)),
        .out_valid (f1_valid),
        .out_quo   (f1_quo),
        .out_ovf   (f1_ovf),
        .out_side  (f1_side)
    );

    ssd_div u_div_fres2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (d_vld_reg),
        .in_num    (d_num2_reg),
        .in_den    (d_den2_reg),
        .in_side   ({SIDE_W{1'b0}}),
        .out_valid (f2_valid),
        .out_quo   (f2_quo),
        .out_ovf   (f2_ovf),
        .out_side  ()
    );

    assign f_side = fres_t'(f1_side[FRES_W-1:0]);

    // square stage; a zero sum makes the squared term one
    logic        r1_vld_reg;
    logic [30:0] r1_sq1_reg, r1_sq2_reg;
    fres_t       r1_side_reg;

    // reflectance stage
    logic        r2_vld_reg;
    logic [15:0] r2_refl_reg;
    logic [15:0] r2_prob_reg;
    fres_t       r2_side_reg;
    logic [31:0] sq_sum;
    logic [15:0] refl_raw;
    logic [15:0] refl_next;

    always_comb
    begin
        sq_sum   = 32'(r1_sq1_reg) + 32'(r1_sq2_reg);
        refl_raw = 16'(sq_sum >> 16);
        if (r1_side_reg.cost == 16'd0 || refl_raw > ONE_Q15)
            refl_next = ONE_Q15;
        else
            refl_next = refl_raw;
    end

    // selection stage: lobe choice, direction, pdf and weight operands
    logic               r3_vld_reg;
    logic [DIV_N_W-1:0] r3_num_reg;
    logic [DIV_D_W-1:0] r3_den_reg;
    sel_t               r3_sel_reg;
    sel_t               sel_next;
    logic [15:0]        share;
    logic [15:0]        cosv;
    logic               both, take_r, take_t;
    logic [16:0]        two_prob;
    logic [16:0]        xs, ys, zs, tx, ty, tz;
    fres_t              rs;

    always_comb
    begin
        rs       = r2_side_reg;
        both     = rs.refl_ok && rs.trans_ok;
        two_prob = {r2_prob_reg, 1'b0};
        take_r   = (r2_refl_reg != 16'd0)
                   && ((both && (17'(rs.smp) <= two_prob)) || (rs.refl_ok && !both));
        take_t   = !take_r && (r2_refl_reg < ONE_Q15)
                   && ((both && (17'(rs.smp) > two_prob)) || (rs.trans_ok && !both));
        xs       = {rs.x[15], rs.x};
        ys       = {rs.y[15], rs.y};
        zs       = rs.entering ? {1'b0, rs.abs_z} : 17'(17'd0 - {1'b0, rs.abs_z});

        // refracted x and y, saturated to 17 bits
        if (rs.x[15])
            tx = (rs.mx[17:16] != 2'd0) ? 17'h0FFFF : {1'b0, rs.mx[15:0]};
        else
            tx = (rs.mx > 18'd65536) ? 17'h10000 : 17'(18'd0 - rs.mx);
        if (rs.y[15])
            ty = (rs.my[17:16] != 2'd0) ? 17'h0FFFF : {1'b0, rs.my[15:0]};
        else
            ty = (rs.my > 18'd65536) ? 17'h10000 : 17'(18'd0 - rs.my);
        tz = rs.entering ? 17'(17'd0 - {1'b0, rs.cost}) : {1'b0, rs.cost};

        sel_next = '0;
        share    = 16'd0;
        cosv     = 16'd0;
        if (take_r)
        begin
            sel_next.dx   = 17'(17'd0 - xs);
            sel_next.dy   = 17'(17'd0 - ys);
            sel_next.dz   = zs;
            sel_next.prob = both ? r2_prob_reg : ONE_Q15;
            sel_next.lum  = 1'b1;
            sel_next.lobe = LOBE_REFL;
            share         = r2_refl_reg;
            cosv          = rs.abs_z;
        end
        else if (take_t)
        begin
            sel_next.dx   = tx;
            sel_next.dy   = ty;
            sel_next.dz   = tz;
            sel_next.prob = both ? 16'(ONE_Q15 - r2_prob_reg) : ONE_Q15;
            sel_next.lum  = 1'b0;
            sel_next.lobe = LOBE_TRANS;
            share         = 16'(ONE_Q15 - r2_refl_reg);
            cosv          = rs.cost;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_vld_reg <= 1'b0;
            r2_vld_reg <= 1'b0;
            r3_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            r1_vld_reg <= f1_valid && f2_valid;
            r2_vld_reg <= r1_vld_reg;
            r3_vld_reg <= r2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_sq1_reg  <= f1_ovf ? SIN2_ONE
                                  : 31'(32'(f1_quo[15:0]) * 32'(f1_quo[15:0]));
            r1_sq2_reg  <= f2_ovf ? SIN2_ONE
                                  : 31'(32'(f2_quo[15:0]) * 32'(f2_quo[15:0]));
            r1_side_reg <= f_side;
            r2_refl_reg <= refl_next;
            r2_prob_reg <= 16'(refl_next >> 1) + 16'd8192;
            r2_side_reg <= r1_side_reg;
            r3_num_reg  <= DIV_N_W'(share) << 16;
            r3_den_reg  <= DIV_D_W'(cosv);
            r3_sel_reg  <= sel_next;
        end
    end

    // weight division
    logic               w_valid, w_ovf;
    logic [DIV_Q_W-1:0] w_quo;
    logic [SIDE_W-1:0]  w_side;
    sel_t               w_sel;
    logic [23:0]        weight_next;

    ssd_div u_div_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (r3_vld_reg),
        .in_num    (r3_num_reg),
        .in_den    (r3_den_reg),
        .in_side   (SIDE_W'(r3_sel_reg)),
        .out_valid (w_valid),
        .out_quo   (w_quo),
        .out_ovf   (w_ovf),
        .out_side  (w_side)
    );

    assign w_sel = sel_t'(w_side[SEL_W-1:0]);

    always_comb
    begin
        if (w_sel.lobe == LOBE_NONE)
            weight_next = 24'd0;
        else if (w_ovf || w_quo[DIV_Q_W-1])
            weight_next = WEIGHT_MAX;
        else
            weight_next = w_quo[23:0];
    end

    // output register
    logic [95:0] out_data_reg;
    logic [2:0]  out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= w_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {5'd0, weight_next, w_sel.prob, w_sel.dz, w_sel.dy, w_sel.dx};
            out_user_reg <= {w_sel.lobe, w_sel.lum};
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ssd_check.sv
// Port-level checks for the dielectric specular sampler, bound to the top.
// Depends on ssd_pkg and dielectric_specular_sampler.
`default_nettype none

module ssd_check
    import ssd_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [95:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser
);

    // held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // no-lobe result carries all zeros
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[2:1] == LOBE_NONE) |->
            (m_axis_tdata == 96'd0) && !m_axis_tuser[0])
        else $error("no-lobe result not zero");

    // luminance flag goes with reflection only
    a_lum: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tuser[2:1] == LOBE_REFL)))
        else $error("luminance flag mismatch");

    // pdf never above one
    a_pdf: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[66:51] <= ONE_Q15))
        else $error("pdf above one");

endmodule

bind dielectric_specular_sampler ssd_check u_ssd_check (.*);

`default_nettype wire
